>>> rtl/i2ra_pkg.sv
// Shared types and constants for the int64 to radix ASCII converter.
// Used by i2ra_ctrl, i2ra_dp and int64_to_radix_ascii; no dependencies.
package i2ra_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned RadixW    = 6;
  localparam int unsigned CharW     = 8;
  localparam int unsigned MaxDigits = 64;
  localparam int unsigned DigitAw   = $clog2(MaxDigits);
  localparam int unsigned CountW    = DigitAw + 1;
  // quotient bits resolved per divider cycle
  localparam int unsigned DivBits   = 4;
  localparam int unsigned StepW     = $clog2(ValueW / DivBits);

  localparam logic [RadixW-1:0] RadixMin   = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax   = RadixW'(36);
  localparam logic [RadixW-1:0] RadixSign  = RadixW'(10);
  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharLowZ  = 8'h7a;
  localparam logic [CharW-1:0] CharMinus = 8'h2d;

  // controller to datapath
  typedef struct packed {
    logic load;       // take a new value, start the first digit
    logic div_step;   // run one divider step
    logic sign_load;  // put '-' in the output register
    logic rd_issue;   // read the next stored digit, count down
    logic char_load;  // put the read digit in the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic digit_done; // this divider cycle finishes a digit
    logic quo_zero;   // quotient after this cycle is zero
    logic count_full; // this digit fills the store
    logic sign;       // a minus sign precedes the digits
    logic out_free;   // output register can take a character
    logic last;       // the digit just read is the least significant
  } sts_t;

  // Map a digit value to its ASCII character.
  function automatic logic [CharW-1:0] digit_char(input logic [RadixW-1:0] d);
    logic [CharW-1:0] c;
    if (d < RadixW'(10)) begin
      c = CharZero + CharW'(d);
    end else begin
      c = CharLowA + CharW'(d) - CharW'(10);
    end
    return c;
  endfunction

endpackage

>>> rtl/i2ra_ctrl.sv
// Sequencer for the converter: divide, then emit sign and digits.
// Depends on i2ra_pkg for the command and status structs.
module i2ra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  i2ra_pkg::sts_t sts_i,
  output i2ra_pkg::cmd_t cmd_o
);
  import i2ra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.digit_done && (sts_i.quo_zero || sts_i.count_full)) begin
          state_d = sts_i.sign ? S_SIGN : S_READ;
        end
      end
      S_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.sign_load = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.char_load = 1'b1;
          state_d         = sts_i.last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/i2ra_dp.sv
// Datapath: radix register, 4-bit-per-cycle divider, digit store, output register.
// Depends on i2ra_pkg; driven by i2ra_ctrl through cmd_t / sts_t.
module i2ra_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [i2ra_pkg::RadixW-1:0]  number_base_i,
  input  logic [i2ra_pkg::ValueW-1:0]  number_in_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [i2ra_pkg::CharW-1:0]   text_char_o,
  output logic                         end_of_text_o,
  input  i2ra_pkg::cmd_t               cmd_i,
  output i2ra_pkg::sts_t               sts_o
);
  import i2ra_pkg::*;

  logic [RadixW-1:0]  base_q;
  logic [RadixW-1:0]  radix_q;
  logic [RadixW-1:0]  radix_eff;
  logic [ValueW-1:0]  quo_q, quo_d;
  logic [RadixW-1:0]  rem_q, rem_d;
  logic [StepW-1:0]   step_q;
  logic [CountW-1:0]  count_q;
  logic               sign_q;
  logic               neg_in;
  logic [RadixW-1:0]  rd_q;
  logic               out_valid_q;
  logic [CharW-1:0]   out_char_q;
  logic               out_last_q;
  logic               out_free;
  logic               digit_done;
  logic [RadixW-1:0]  mem [MaxDigits];

  // Clamp the configured radix into range
  always_comb begin
    radix_eff = base_q;
    if (base_q < RadixMin) begin
      radix_eff = RadixMin;
    end else if (base_q > RadixMax) begin
      radix_eff = RadixMax;
    end
  end

  assign neg_in = number_in_i[ValueW-1] && (radix_eff == RadixSign);

  // Restoring division, DivBits quotient bits per cycle
  always_comb begin
    logic [RadixW:0] t;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < DivBits; i++) begin
      t     = {rem_d, quo_d[ValueW-1]};
      quo_d = {quo_d[ValueW-2:0], 1'b0};
      if (t >= {1'b0, radix_q}) begin
        t        = t - {1'b0, radix_q};
        quo_d[0] = 1'b1;
      end
      rem_d = t[RadixW-1:0];
    end
  end

  assign digit_done = cmd_i.div_step && (step_q == {StepW{1'b1}});
  assign out_free   = !out_valid_q || !out_stall_i;

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= RadixReset;
    end else if (cfg_valid_i) begin
      base_q <= number_base_i;
    end
  end

  // Divider, digit count and sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q   <= '0;
      rem_q   <= '0;
      step_q  <= '0;
      count_q <= '0;
      sign_q  <= 1'b0;
      radix_q <= RadixReset;
    end else if (cmd_i.load) begin
      quo_q   <= neg_in ? (ValueW'(0) - number_in_i) : number_in_i;
      rem_q   <= '0;
      step_q  <= '0;
      count_q <= '0;
      sign_q  <= neg_in;
      radix_q <= radix_eff;
    end else if (cmd_i.div_step) begin
      quo_q  <= quo_d;
      step_q <= step_q + StepW'(1);
      if (digit_done) begin
        rem_q   <= '0;
        count_q <= count_q + CountW'(1);
      end else begin
        rem_q <= rem_d;
      end
    end else if (cmd_i.rd_issue) begin
      count_q <= count_q - CountW'(1);
    end
  end

  // Digit store: write on digit completion, registered read
  always_ff @(posedge clk_i) begin
    if (digit_done) begin
      mem[count_q[DigitAw-1:0]] <= rem_d;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem[DigitAw'(count_q - CountW'(1))];
    end
  end

  // Output register: hold while stalled, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.sign_load || cmd_i.char_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sign_load) begin
      out_char_q <= CharMinus;
      out_last_q <= 1'b0;
    end else if (cmd_i.char_load) begin
      out_char_q <= digit_char(rd_q);
      out_last_q <= (count_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign text_char_o   = out_char_q;
  assign end_of_text_o = out_last_q;

  assign sts_o.digit_done = digit_done;
  assign sts_o.quo_zero   = (quo_d == '0);
  assign sts_o.count_full = (count_q == CountW'(MaxDigits - 1));
  assign sts_o.sign       = sign_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.last       = (count_q == '0);

endmodule

>>> rtl/int64_to_radix_ascii.sv
// Top level of the int64 to radix ASCII converter.
// Depends on i2ra_pkg, i2ra_ctrl and i2ra_dp.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  input    | in_valid_i / in_stall_o    | number_in_i [63:0]
//  output   | out_valid_o / out_stall_i  | text_char_o [7:0], end_of_text_o
//  config   | cfg_valid_i / cfg_ready_o  | number_base_i [5:0]
//
// Each digit is worked out in the divider, which resolves 4 quotient bits a cycle;
// each character then passes a read state and an emit state for the digit
// store's registered read, and an emit waits while the output register is busy.
// Radix ten needs at most 19 digits and a sign, radix two 64.
// Reset is asynchronous and needs no clearing pass; radix resets to ten.
// A stalled output holds its character; the next item is taken once the last
// character of the current one sits in the output register.
module int64_to_radix_ascii (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [i2ra_pkg::RadixW-1:0]  number_base_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [i2ra_pkg::ValueW-1:0]  number_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [i2ra_pkg::CharW-1:0]   text_char_o,
  output logic                         end_of_text_o
);
  import i2ra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  i2ra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  i2ra_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .number_base_i (number_base_i),
    .number_in_i   (number_in_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .text_char_o   (text_char_o),
    .end_of_text_o (end_of_text_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  // An accepted value keeps the input stalled while it is converted
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("input not stalled after accepting a value");

  // The final character of a run is always a digit
  a_last_not_sign: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_text_o) |-> (text_char_o != CharMinus)
  ) else $error("run ends on a minus sign");

  // Only digits, lower-case letters and the minus sign come out
  a_char_set: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((text_char_o >= CharZero && text_char_o <= CharNine) ||
                     (text_char_o >= CharLowA && text_char_o <= CharLowZ) ||
                     (text_char_o == CharMinus))
  ) else $error("character outside the output set");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for int64_to_radix_ascii: drives numbers and radix writes,
// predicts the ASCII text of each number and compares it character by character.
// Depends on i2ra_pkg and the int64_to_radix_ascii RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2ra_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  // Predicts the character run of each accepted number and checks the outputs.
  class radix_text_board;
    logic [RadixW-1:0] radix_reg;
    text_char_t        chars_due[$];
    int unsigned       mismatches;

    function new();
      radix_reg  = RadixReset;
      mismatches = 0;
    endfunction

    function void set_radix(input logic [RadixW-1:0] r);
      radix_reg = r;
    endfunction

    // Convert one accepted value to its expected characters.
    function void note_number(input logic [ValueW-1:0] value);
      logic [ValueW-1:0] base;
      logic [ValueW-1:0] mag;
      logic              neg;
      logic [RadixW-1:0] digits[$];
      text_char_t        c;
      base = ValueW'(radix_reg);
      if (base < ValueW'(RadixMin)) base = ValueW'(RadixMin);
      if (base > ValueW'(RadixMax)) base = ValueW'(RadixMax);
      neg = value[ValueW-1] && (base == ValueW'(RadixSign));
      mag = neg ? (~value + 1'b1) : value;
      do begin
        digits.push_front(RadixW'(mag % base));
        mag = mag / base;
      end while (mag != '0);
      if (neg) begin
        c.ch   = CharMinus;
        c.last = 1'b0;
        chars_due.push_back(c);
      end
      foreach (digits[i]) begin
        if (digits[i] < RadixW'(10)) begin
          c.ch = CharZero + CharW'(digits[i]);
        end else begin
          c.ch = CharLowA + CharW'(digits[i] - RadixW'(10));
        end
        c.last = (i == digits.size() - 1);
        chars_due.push_back(c);
      end
    endfunction

    // Compare one accepted output transaction with the oldest expectation.
    function void check_char(input logic [CharW-1:0] ch, input logic last);
      text_char_t want;
      if (chars_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected char 0x%02h last=%0b", $realtime, ch, last);
        end
      end else begin
        want = chars_due.pop_front();
        if (ch !== want.ch || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: char mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                     $realtime, want.ch, want.last, ch, last);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return chars_due.size();
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid     = 1'b0;
  logic [RadixW-1:0] number_base   = RadixReset;
  logic              in_valid      = 1'b0;
  logic [ValueW-1:0] number_in     = '0;
  logic              out_stall     = 1'b0;
  logic              cfg_ready;
  logic              in_stall;
  logic              out_valid;
  logic [CharW-1:0]  text_char;
  logic              end_of_text;

  int unsigned       in_gap_pct    = 0;
  int unsigned       stall_pct     = 0;

  radix_text_board   board = new();

  int64_to_radix_ascii DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .number_base_i (number_base),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .number_in_i   (number_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .text_char_o   (text_char),
    .end_of_text_o (end_of_text)
  );

  always #10 clk_i = ~clk_i;

  // Stall the output in short random bursts.
  always begin
    @(posedge clk_i);
    if (rst_ni && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
      out_stall <= 1'b0;
    end
  end

  // Check every output transaction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      board.check_char(text_char, end_of_text);
    end
  end

  // Write the radix register; only called while the block is idle.
  task automatic write_radix(input logic [RadixW-1:0] r);
    cfg_valid   <= 1'b1;
    number_base <= r;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_radix(r);
  endtask

  // Send one number, with an optional idle burst ahead of it.
  task automatic send_number(input logic [ValueW-1:0] value);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    number_in <= value;
    do @(posedge clk_i); while (in_stall);
    board.note_number(value);
  endtask

  // Hold off the sender until every expected character has come.
  task automatic drain_text();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [ValueW-1:0] pick_number();
    logic [ValueW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      1: v = ValueW'($urandom_range(0, 1000));
      2: v = ~ValueW'($urandom_range(0, 1000)) + 1'b1;
      3: v = v >> $urandom_range(0, 63);
      4: v = ~(v >> $urandom_range(0, 63)) + 1'b1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [RadixW-1:0] pick_radix();
    logic [RadixW-1:0] r;
    case ($urandom_range(0, 9))
      0: r = RadixW'($urandom_range(0, 1));
      1: r = RadixW'($urandom_range(37, 63));
      2: r = RadixSign;
      default: r = RadixW'($urandom_range(2, 36));
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 35;
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset radix ten, sign handling and the most negative value.
    in_gap_pct = 20;
    stall_pct  = 20;
    send_number(64'd0);
    send_number(64'd1);
    send_number({ValueW{1'b1}});
    send_number(64'd9);
    send_number(64'd10);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'h7fff_ffff_ffff_ffff);
    send_number(~64'd10 + 1'b1);
    drain_text();

    // Radix below two acts as binary: all ones gives the longest run.
    write_radix(RadixW'(0));
    send_number({ValueW{1'b1}});
    send_number(64'd0);
    send_number(64'd1);
    drain_text();

    // Largest field value acts as radix thirty-six; letters up to 'z'.
    write_radix(RadixW'(63));
    send_number(64'd35);
    send_number(64'd36);
    send_number({ValueW{1'b1}});
    send_number(64'h8000_0000_0000_0000);
    drain_text();

    write_radix(RadixW'(16));
    send_number(64'hdead_beef_0123_4567);
    send_number({ValueW{1'b1}});
    drain_text();

    write_radix(RadixW'(1));
    send_number(64'd5);
    drain_text();

    write_radix(RadixW'(37));
    send_number(64'd71);
    drain_text();

    write_radix(RadixMax);
    send_number(64'h7fff_ffff_ffff_ffff);
    drain_text();

    // Random phases, each under one radix and its own idling mix.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) begin
        in_gap_pct = 0;
        stall_pct  = 0;
      end else begin
        in_gap_pct = pick_pct();
        stall_pct  = pick_pct();
      end
      write_radix(pick_radix());
      for (int k = 0; k < 18; k++) begin
        send_number(pick_number());
      end
      drain_text();
    end

    repeat (40) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #25ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
